FILE: src/nmea_pkg.sv
// ----------------------------------------------------------------------------
// nmea_pkg
// Shared constants and small lookup functions for the GGA position parser.
// ----------------------------------------------------------------------------
package nmea_pkg;

   // Default longest line, in bytes, that is counted and parsed
   localparam int MAX_LINE_DEFAULT = 128;

   // Characters
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_N     = 8'h4E;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_W     = 8'h57;

   // Result status codes
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_SUM   = 3'd1,
      STATUS_NOT_GGA   = 3'd2,
      STATUS_BAD_HEMI  = 3'd3,
      STATUS_TOO_SHORT = 3'd4
   } status_type;

   // Trailer phases
   typedef enum logic [1:0] {
      TRL_NONE  = 2'd0,
      TRL_HIGH  = 2'd1,
      TRL_LOW   = 2'd2,
      TRL_DONE  = 2'd3
   } trailer_type;

   // Field numbers of interest
   localparam logic [3:0] FIELD_LAT     = 4'd2;
   localparam logic [3:0] FIELD_LAT_HEM = 4'd3;
   localparam logic [3:0] FIELD_LON     = 4'd4;
   localparam logic [3:0] FIELD_LON_HEM = 4'd5;

   // Held position after reset (1e-7 degree)
   localparam logic signed [30:0] LAT_RESET = 31'sd576345030;
   localparam logic signed [34:0] LON_RESET = 35'sd119578160;

   // Fixed-point scaling: deg*1e7 + min*50/3, divide by 3 via reciprocal
   localparam logic [23:0] DEG_SCALE = 24'd10000000;
   localparam logic [5:0]  MIN_SCALE = 6'd50;
   localparam int          RECIP_SHIFT = 27;
   localparam logic [25:0] RECIP_3 = 26'd44739243;   // (2^27 + 1) / 3

   // Header text "$GPGGA" by position
   function automatic logic [7:0] hdr_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = 8'h24;
         3'd1:    ch = 8'h47;
         3'd2:    ch = 8'h50;
         3'd3:    ch = 8'h47;
         3'd4:    ch = 8'h47;
         3'd5:    ch = 8'h41;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Hex digit value, anything but 0-9 and A-F reads as 0
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      if (c >= 8'h30 && c <= 8'h39)      v = 4'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
      else                               v = 4'd0;
      return v;
   endfunction

   // Degree digit weights
   function automatic logic [6:0] deg_weight(input logic is_lon, input logic [3:0] pos);
      logic [6:0] w;
      unique case (pos)
         4'd0:    w = is_lon ? 7'd100 : 7'd10;
         4'd1:    w = is_lon ? 7'd10  : 7'd1;
         4'd2:    w = is_lon ? 7'd1   : 7'd0;
         default: w = 7'd0;
      endcase
      return w;
   endfunction

   // Minute digit weights (minutes * 1e4); the decimal point slot weighs 0
   function automatic logic [16:0] min_weight(input logic is_lon, input logic [3:0] pos);
      logic [16:0] w;
      logic [3:0]  p;
      p = is_lon ? 4'(pos - 4'd1) : pos;
      if (is_lon && pos == 4'd0) p = 4'd0;
      unique case (p)
         4'd2:    w = 17'd100000;
         4'd3:    w = 17'd10000;
         4'd5:    w = 17'd1000;
         4'd6:    w = 17'd100;
         4'd7:    w = 17'd10;
         4'd8:    w = 17'd1;
         default: w = 17'd0;
      endcase
      return w;
   endfunction

endpackage

FILE: src/nmea_gga_position_parser_top.sv
// ----------------------------------------------------------------------------
// nmea_gga_position_parser_top
// Parses GGA sentences byte by byte and reports the held position per line.
// ----------------------------------------------------------------------------
//  channel | ports      | width | content
//  --------+------------+-------+------------------------------------------
//  input   | req_t*     |   8   | rx_byte
//  result  | rsp_t*     |  72   | status, latitude_e7, longitude_e7
//
// One byte per cycle unless a waiting result stalls input; each accepted byte
// updates the registered line state and a line feed loads the result register.
// Reset (synchronous) clears the line state and loads the default position.
// A waiting result stalls input only when it is not taken in that cycle.
module nmea_gga_position_parser_top #(
   parameter int MAX_LINE = nmea_pkg::MAX_LINE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [2:0] status, [33:3] latitude_e7,
                                    // [68:34] longitude_e7, [71:69] zero
);

   // Line state
   logic [7:0]  len_ff, len_in;
   logic [2:0]  hdr_ff, hdr_in;
   logic [3:0]  field_ff, field_in;
   logic [3:0]  cif_ff, cif_in;
   logic [7:0]  xor_ff, xor_in;
   nmea_pkg::trailer_type trl_ff, trl_in;
   logic [7:0]  rsum_ff, rsum_in;
   logic [9:0]  deg_ff, deg_in;
   logic [19:0] min_ff, min_in;
   logic [30:0] plat_ff, plat_in;
   logic [34:0] plon_ff, plon_in;
   logic [4:0]  flags_ff, flags_in;
   logic signed [30:0] hlat_ff, hlat_in;
   logic signed [34:0] hlon_ff, hlon_in;

   // Result register
   logic        rvalid_ff, rvalid_in;
   logic [71:0] rdata_ff, rdata_in;

   logic accept;
   logic [7:0] c;
   assign c          = req_tdata;
   assign req_tready = !rvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;

   // End-of-field position value: deg*1e7 + floor(min*50/3)
   logic [25:0] min50;
   logic [51:0] recip_prod;
   logic [34:0] field_val;
   logic        ef_lat, ef_lon;
   assign min50      = 26'(min_ff) * 26'(nmea_pkg::MIN_SCALE);
   assign recip_prod = 52'(min50) * 52'(nmea_pkg::RECIP_3);
   assign field_val  = 35'(deg_ff) * 35'(nmea_pkg::DEG_SCALE)
                     + 35'(recip_prod[51:nmea_pkg::RECIP_SHIFT]);
   assign ef_lat     = (field_ff == nmea_pkg::FIELD_LAT) && (cif_ff != 4'd0);
   assign ef_lon     = (field_ff == nmea_pkg::FIELD_LON) && (cif_ff != 4'd0);

   // Next-state logic
   always_comb begin
      logic [30:0] lat_v;
      logic [34:0] lon_v;
      logic [4:0]  fl;
      logic [3:0]  d;
      logic        in_lat, in_lon;
      nmea_pkg::status_type st;

      len_in = len_ff;   hdr_in = hdr_ff;   field_in = field_ff; cif_in = cif_ff;
      xor_in = xor_ff;   trl_in = trl_ff;   rsum_in = rsum_ff;
      deg_in = deg_ff;   min_in = min_ff;
      plat_in = plat_ff; plon_in = plon_ff; flags_in = flags_ff;
      hlat_in = hlat_ff; hlon_in = hlon_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rdata_in  = rdata_ff;

      lat_v = plat_ff; lon_v = plon_ff; fl = flags_ff;
      d = (c >= 8'h30 && c <= 8'h39) ? 4'(c - 8'h30) : 4'd0;
      in_lat = (field_ff == nmea_pkg::FIELD_LAT);
      in_lon = (field_ff == nmea_pkg::FIELD_LON);
      st = nmea_pkg::STATUS_OK;

      if (accept && c == nmea_pkg::CHAR_LF) begin
         // close the open field unless a trailer started
         if (trl_ff == nmea_pkg::TRL_NONE) begin
            if (ef_lat) begin lat_v = field_val[30:0]; fl[0] = 1'b1; end
            if (ef_lon) begin lon_v = field_val;       fl[2] = 1'b1; end
         end
         priority if (len_ff < 8'd3)                          st = nmea_pkg::STATUS_TOO_SHORT;
         else if (trl_ff != nmea_pkg::TRL_NONE && rsum_ff != xor_ff)
                                                              st = nmea_pkg::STATUS_BAD_SUM;
         else if (hdr_ff < 3'd6)                              st = nmea_pkg::STATUS_NOT_GGA;
         else if (fl[4])                                      st = nmea_pkg::STATUS_BAD_HEMI;
         else                                                 st = nmea_pkg::STATUS_OK;
         if (st == nmea_pkg::STATUS_OK) begin
            if (fl[0]) hlat_in = fl[1] ? 31'(-lat_v) : lat_v;
            if (fl[2]) hlon_in = fl[3] ? 35'(-lon_v) : lon_v;
         end
         rvalid_in = 1'b1;
         rdata_in  = {3'd0, 35'(hlon_in), 31'(hlat_in), 3'(st)};
         // clear the line
         len_in = '0; hdr_in = '0; field_in = '0; cif_in = '0; xor_in = '0;
         trl_in = nmea_pkg::TRL_NONE; rsum_in = '0; deg_in = '0; min_in = '0;
         plat_in = '0; plon_in = '0; flags_in = '0;
      end else if (accept && len_ff < 8'(MAX_LINE)) begin
         len_in = len_ff + 8'd1;
         if (len_ff < 8'd6 && 8'(hdr_ff) == len_ff
             && c == nmea_pkg::hdr_char(len_ff[2:0]))
            hdr_in = hdr_ff + 3'd1;

         unique case (trl_ff)
            nmea_pkg::TRL_NONE: begin
               if (c == nmea_pkg::CHAR_STAR || c == nmea_pkg::CHAR_COMMA) begin
                  if (ef_lat) begin plat_in = field_val[30:0]; flags_in[0] = 1'b1; end
                  if (ef_lon) begin plon_in = field_val;       flags_in[2] = 1'b1; end
                  deg_in = '0;
                  min_in = '0;
               end
               if (c == nmea_pkg::CHAR_STAR) begin
                  trl_in = nmea_pkg::TRL_HIGH;
               end else begin
                  if (len_ff != 8'd0) xor_in = xor_ff ^ c;
                  if (c == nmea_pkg::CHAR_COMMA) begin
                     if (field_ff != 4'd15) field_in = field_ff + 4'd1;
                     cif_in = '0;
                  end else begin
                     // digit or hemisphere character
                     if (in_lat || in_lon) begin
                        deg_in = deg_ff + 10'(d) * 10'(nmea_pkg::deg_weight(in_lon, cif_ff));
                        min_in = min_ff + 20'(21'(d) * 21'(nmea_pkg::min_weight(in_lon, cif_ff)));
                     end else if (field_ff == nmea_pkg::FIELD_LAT_HEM && cif_ff == 4'd0) begin
                        if (c == nmea_pkg::CHAR_S)      flags_in[1] = 1'b1;
                        else if (c != nmea_pkg::CHAR_N) flags_in[4] = 1'b1;
                     end else if (field_ff == nmea_pkg::FIELD_LON_HEM && cif_ff == 4'd0) begin
                        if (c == nmea_pkg::CHAR_W)      flags_in[3] = 1'b1;
                        else if (c != nmea_pkg::CHAR_E) flags_in[4] = 1'b1;
                     end
                     if (cif_ff != 4'd15) cif_in = cif_ff + 4'd1;
                  end
               end
            end
            nmea_pkg::TRL_HIGH: begin
               rsum_in = {nmea_pkg::hex_value(c), 4'd0};
               trl_in  = nmea_pkg::TRL_LOW;
            end
            nmea_pkg::TRL_LOW: begin
               rsum_in = {rsum_ff[7:4], nmea_pkg::hex_value(c)};
               trl_in  = nmea_pkg::TRL_DONE;
            end
            nmea_pkg::TRL_DONE: begin
               trl_in = nmea_pkg::TRL_DONE;
            end
            default: trl_in = trl_ff;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0; hdr_ff <= '0; field_ff <= '0; cif_ff <= '0; xor_ff <= '0;
         trl_ff <= nmea_pkg::TRL_NONE; rsum_ff <= '0; deg_ff <= '0; min_ff <= '0;
         plat_ff <= '0; plon_ff <= '0; flags_ff <= '0;
         hlat_ff <= nmea_pkg::LAT_RESET;
         hlon_ff <= nmea_pkg::LON_RESET;
         rvalid_ff <= 1'b0;
      end else begin
         len_ff <= len_in; hdr_ff <= hdr_in; field_ff <= field_in; cif_ff <= cif_in;
         xor_ff <= xor_in; trl_ff <= trl_in; rsum_ff <= rsum_in;
         deg_ff <= deg_in; min_ff <= min_in;
         plat_ff <= plat_in; plon_ff <= plon_in; flags_ff <= flags_in;
         hlat_ff <= hlat_in; hlon_ff <= hlon_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rdata_ff <= rdata_in;
   end

endmodule

FILE: dv/tb_nmea_gga_position_parser_top.sv
// ----------------------------------------------------------------------------
// tb_nmea_gga_position_parser_top
// Streams GGA sentences, broken lines and noise into the parser and checks
// every line-feed result against a behavioral position predictor.
// ----------------------------------------------------------------------------
module tb_nmea_gga_position_parser_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LINE = nmea_pkg::MAX_LINE_DEFAULT;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // [2:0] status, [33:3] latitude_e7,
                             // [68:34] longitude_e7, [71:69] zero

   // Packed with status in the lowest bits, as on rsp_tdata
   typedef struct packed {
      logic signed [34:0]   lon;
      logic signed [30:0]   lat;
      nmea_pkg::status_type status;
   } fix_type;

   nmea_gga_position_parser_top #(.MAX_LINE(MAX_LINE)) dut (.*);

   // Predictor state
   int unsigned    p_len, p_hdr, p_field, p_char, p_xor, p_sum, p_deg, p_min, p_flags;
   nmea_pkg::trailer_type p_trl;
   logic [30:0]    p_plat;
   logic [34:0]    p_plon;
   logic signed [30:0] p_held_lat;
   logic signed [34:0] p_held_lon;

   logic [7:0] byte_queue[$];
   fix_type    fix_queue[$];
   int         mismatches;

   function automatic int unsigned hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return 0;
   endfunction

   function automatic void clear_line();
      p_len = 0; p_hdr = 0; p_field = 0; p_char = 0; p_xor = 0; p_sum = 0;
      p_deg = 0; p_min = 0; p_flags = 0; p_plat = '0; p_plon = '0;
      p_trl = nmea_pkg::TRL_NONE;
   endfunction

   function automatic void close_field();
      longint unsigned v;
      if ((p_field == 2 || p_field == 4) && p_char > 0) begin
         v = longint'(p_deg) * 10000000 + (longint'(p_min) * 50) / 3;
         if (p_field == 2) begin
            p_plat = v[30:0]; p_flags |= 1;
         end else begin
            p_plon = v[34:0]; p_flags |= 4;
         end
      end
      p_deg = 0; p_min = 0;
   endfunction

   // Digit weights: latitude dd mm.ffff, longitude ddd mm.ffff
   function automatic void field_char(input logic [7:0] c);
      int unsigned d, pos, q;
      pos = p_char;
      d = (c >= "0" && c <= "9") ? c - "0" : 0;
      if (p_field == 2 || p_field == 4) begin
         q = (p_field == 4) ? pos : pos + 1;  // align to longitude slots
         case (q)
            0: p_deg += d * 100;
            1: p_deg += d * 10;
            2: p_deg += d;
            3: p_min += d * 100000;
            4: p_min += d * 10000;
            6: p_min += d * 1000;
            7: p_min += d * 100;
            8: p_min += d * 10;
            9: p_min += d;
            default: ;
         endcase
      end else if (p_field == 3 && pos == 0) begin
         if (c == nmea_pkg::CHAR_S) p_flags |= 2;
         else if (c != nmea_pkg::CHAR_N) p_flags |= 16;
      end else if (p_field == 5 && pos == 0) begin
         if (c == nmea_pkg::CHAR_W) p_flags |= 8;
         else if (c != nmea_pkg::CHAR_E) p_flags |= 16;
      end
      if (p_char < 15) p_char++;
   endfunction

   // Advance predictor by one byte; returns 1 with a fix on line feed
   function automatic bit parse_byte(input logic [7:0] c, output fix_type f);
      nmea_pkg::status_type st;
      f = '0;
      if (c == nmea_pkg::CHAR_LF) begin
         if (p_trl == nmea_pkg::TRL_NONE) close_field();
         if (p_len < 3) st = nmea_pkg::STATUS_TOO_SHORT;
         else if (p_trl != nmea_pkg::TRL_NONE && p_sum != p_xor) st = nmea_pkg::STATUS_BAD_SUM;
         else if (p_hdr < 6) st = nmea_pkg::STATUS_NOT_GGA;
         else if (p_flags & 16) st = nmea_pkg::STATUS_BAD_HEMI;
         else st = nmea_pkg::STATUS_OK;
         if (st == nmea_pkg::STATUS_OK) begin
            if (p_flags & 1) p_held_lat = (p_flags & 2) ? -$signed(p_plat) : $signed(p_plat);
            if (p_flags & 4) p_held_lon = (p_flags & 8) ? -$signed(p_plon) : $signed(p_plon);
         end
         f.status = st; f.lat = p_held_lat; f.lon = p_held_lon;
         clear_line();
         return 1;
      end
      if (p_len >= MAX_LINE) return 0;
      if (p_len < 6 && p_hdr == p_len && c == nmea_pkg::hdr_char(3'(p_len))) p_hdr++;
      case (p_trl)
         nmea_pkg::TRL_NONE: begin
            if (c == nmea_pkg::CHAR_STAR) begin
               close_field(); p_trl = nmea_pkg::TRL_HIGH;
            end else begin
               if (p_len >= 1) p_xor ^= c;
               if (c == nmea_pkg::CHAR_COMMA) begin
                  close_field();
                  if (p_field < 15) p_field++;
                  p_char = 0;
               end else begin
                  field_char(c);
               end
            end
         end
         nmea_pkg::TRL_HIGH: begin
            p_sum = hex_digit(c) << 4; p_trl = nmea_pkg::TRL_LOW;
         end
         nmea_pkg::TRL_LOW: begin
            p_sum = (p_sum | hex_digit(c)) & 8'hFF; p_trl = nmea_pkg::TRL_DONE;
         end
         default: ;
      endcase
      p_len++;
      return 0;
   endfunction

   // Sentence builders
   function automatic string digits(input int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
      return s;
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
   endfunction

   function automatic string hex2(input logic [7:0] v);
      return $sformatf("%02X", v);
   endfunction

   // Wraps a body in '$', optional checksum and line feed
   function automatic void push_sentence(input string body, input int sum_mode);
      logic [7:0] x;
      x = 0;
      for (int i = 0; i < body.len(); i++) x ^= body[i];
      if (sum_mode == 1) body = {body, "*", hex2(x)};
      else if (sum_mode == 2) body = {body, "*", hex2(x ^ 8'(1 << $urandom_range(0, 7)))};
      else if (sum_mode == 3) body = {body, "*", hex2(x), "zz"};
      push_text({"$", body, "\n"});
   endfunction

   function automatic string random_gga();
      string lat, lon, ns, ew, fs;
      int k;
      k = $urandom_range(0, 9);
      lat = (k == 0) ? "" : {digits(4), ".", digits($urandom_range(0, 6))};
      lon = (k == 1) ? "" : {digits(5), ".", digits($urandom_range(0, 6))};
      case ($urandom_range(0, 9))
         0: ns = ""; 1: ns = "X"; 2, 3, 4: ns = "S"; default: ns = "N";
      endcase
      case ($urandom_range(0, 9))
         0: ew = ""; 1: ew = "n"; 2, 3, 4: ew = "W"; default: ew = "E";
      endcase
      if ($urandom_range(0, 7) == 0) begin
         lat = {digits(2), string'(byte'($urandom_range(33, 126))), digits(4)};
      end
      fs = ",1,08,0.9,545.4,M,46.9,M,,";
      return {"GPGGA,", digits(6), ".00,", lat, ",", ns, ",", lon, ",", ew, fs};
   endfunction

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Driver
   int req_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0; req_tdata <= '0; req_gap <= 0;
      end else if (req_tvalid && !req_tready) begin
      end else if (req_gap > 0) begin
         req_tvalid <= 0; req_gap <= req_gap - 1;
      end else if (byte_queue.size() > 0) begin
         req_tvalid <= 1; req_tdata <= byte_queue.pop_front();
         req_gap <= $urandom_range(0, 8);
      end else begin
         req_tvalid <= 0;
      end
   end

   // Prediction on accepted bytes
   always @(posedge clock) begin
      fix_type f;
      if (!reset && req_tvalid && req_tready)
         if (parse_byte(req_tdata, f)) fix_queue.push_back(f);
   end

   // Monitor with randomized backpressure
   int rsp_gap;
   always @(posedge clock) begin
      fix_type e, a;
      if (reset) begin
         rsp_tready <= 0; rsp_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            a = rsp_tdata[68:0];
            if (fix_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
            end else begin
               e = fix_queue.pop_front();
               if (a.status !== e.status || a.lat !== e.lat || a.lon !== e.lon
                   || rsp_tdata[71:69] !== 3'b0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("exp st=%0d lat=%0d lon=%0d got st=%0d lat=%0d lon=%0d",
                              e.status, e.lat, e.lon, a.status, a.lat, a.lon);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_tready <= 0; rsp_gap <= rsp_gap - 1;
         end else begin
            rsp_tready <= 1;
            rsp_gap <= $urandom_range(0, 8);
         end
      end
   end

   // Stimulus
   initial begin
      string s;
      mismatches = 0;
      p_held_lat = nmea_pkg::LAT_RESET; p_held_lon = nmea_pkg::LON_RESET;
      clear_line();
      reset = 1;
      repeat (6) @(posedge clock);
      reset <= 0;
      // Directed: short lines, header variants, extremes, trailers
      push_text("\n"); push_text("$G\n"); push_text("$GP\n");
      push_sentence("GPGGA,123519,4807.038,N,01131.000,E,1,08", 1);
      push_sentence("GPGGA,1,9959.9999,S,17959.99999,W", 0);
      push_sentence("GPGGA,1,9999.9999,S,99999.9999,W", 1);
      push_sentence("GPGGA,1,0000.0000,N,00000.0000,E", 2);
      push_sentence("GPGGA,1,1234.5678,Q,12345.6789,E", 1);
      push_sentence("GPGGA,1,1234.5678,N,12345.6789,x", 0);
      push_sentence("GPGGA,1,,,,", 1);
      push_sentence("GPGGA,1,12a4.5,N,1b3,E", 3);
      push_sentence("GPGLL,1,1111.1111,N,11111.1111,E", 1);
      push_text("$GPGGA,1,1000.0,N,01000.0,E*ab\n");
      push_text("$GPGGA,1,2000.0,S*\n");
      push_text("$GPGGA,1,2000.0,S*4\n");
      s = "$GPGGA,1,3000.0,N,";
      while (s.len() < MAX_LINE + 20) s = {s, ",", digits(3)};
      push_text({s, "\n"});
      push_text({"$GPGGA,1,", string'(byte'(8'hFF)), string'(byte'(8'h80)), ",N\n"});
      // Random: mostly well-formed sentences, some noise
      while (byte_queue.size() < 1500) begin
         case ($urandom_range(0, 9))
            0: begin
               repeat ($urandom_range(0, 20))
                  byte_queue.push_back(8'($urandom_range(0, 255)));
               byte_queue.push_back(nmea_pkg::CHAR_LF);
            end
            1: push_sentence(random_gga(), 2);
            2: push_sentence(random_gga(), 3);
            3: push_sentence(random_gga(), 0);
            default: push_sentence(random_gga(), 1);
         endcase
      end
      while (byte_queue.size() > 0 || req_tvalid) @(posedge clock);
      while (fix_queue.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("nmea_gga_position_parser_top: match");
      else $display("nmea_gga_position_parser_top: mismatch");
      $finish;
   end

   initial begin
      #20ms;
      $display("nmea_gga_position_parser_top: mismatch");
      $finish;
   end
endmodule
